/* rtl/sfr_pkg.sv */
// Shared constants and types for the streaming find-and-replace block.
package sfr_pkg;

   localparam int MAX_PATTERN_DEF = 8;
   localparam int MAX_REPLACE_DEF = 8;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 4;
   localparam int WORD_W      = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPL_LEN      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPL_BYTES    = 3'd3;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

/* rtl/sfr_cell.sv */
// One window cell: holds a byte, compares it with its pattern byte, shifts toward the head.
module sfr_cell (
   input  logic                        clock,
   input  sfr_pkg::cell_ctrl_type      ctrl,
   input  logic [sfr_pkg::BYTE_W-1:0]  load_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  next_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  pattern_byte,
   output logic [sfr_pkg::BYTE_W-1:0]  held_byte,
   output logic                        match
);

   logic [sfr_pkg::BYTE_W-1:0] byte_ff;
   logic [sfr_pkg::BYTE_W-1:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.load) begin
         byte_in = load_byte;
      end else if (ctrl.shift) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held_byte = byte_ff;
   assign match     = (byte_ff == pattern_byte);

endmodule

/* rtl/stream_find_replace_top.sv */
// Top level of the streaming find-and-replace block.
//
// The block takes a text line one byte item at a time and replaces every leftmost,
// non-overlapping occurrence of the configured pattern (1 to MAX_PATTERN bytes) by the
// configured replacement (0 to MAX_REPLACE bytes); replacement text is never searched
// again. Bytes that may still start a match are held in a row of MAX_PATTERN cells, each
// comparing its byte against the pattern byte at its position and passing its byte to the
// neighbor nearer the head when a byte is released. The block works on one input item at
// a time: an item is taken, checked for a full match or a stable partial match in the
// next cycle, and then each result it causes is produced, one released byte or one
// replacement byte per cycle while the result side is not stalled, with the held
// remainder checked after each release to find whether it is again a pattern prefix.
// A result sits in an output register, so the next item is accepted while the last
// result of the previous one still waits to be taken. On the last byte of a line all
// held bytes are released and the final result carries rsp_line_done; when the line
// leaves nothing to emit, a single marker result with rsp_has_byte low is given instead.
// Configuration registers must be written through the csr_ port only while the block is
// idle; the block itself does not enforce this. An index beyond the four registers is
// ignored.
module stream_find_replace_top #(
   parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sfr_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                             req_line_end,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                             rsp_has_byte,
   output logic                             rsp_line_done,

   input  logic                             csr_wr_en,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sfr_pkg::WORD_W-1:0]       csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
   localparam int RIDX_W = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;
   localparam int BW     = sfr_pkg::BYTE_W;
   localparam int LW     = sfr_pkg::LEN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SHIFT,
      ST_REPL,
      ST_MARK
   } state_type;

   // Configuration registers.
   logic [LW-1:0]                pattern_len_ff;
   logic [sfr_pkg::WORD_W-1:0]   pattern_bytes_ff;
   logic [LW-1:0]                repl_len_ff;
   logic [sfr_pkg::WORD_W-1:0]   repl_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff   <= LW'(1);
         pattern_bytes_ff <= '0;
         repl_len_ff      <= '0;
         repl_bytes_ff    <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            sfr_pkg::CSR_PATTERN_LEN:   pattern_len_ff   <= csr_wdata[LW-1:0];
            sfr_pkg::CSR_PATTERN_BYTES: pattern_bytes_ff <= csr_wdata;
            sfr_pkg::CSR_REPL_LEN:      repl_len_ff      <= csr_wdata[LW-1:0];
            sfr_pkg::CSR_REPL_BYTES:    repl_bytes_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Effective lengths: a zero pattern length counts as one, and both lengths saturate
   // at the size the hardware was built for.
   logic [LW-1:0] plen;
   logic [LW-1:0] rlen;

   always_comb begin
      plen = pattern_len_ff;
      if (pattern_len_ff == '0) begin
         plen = LW'(1);
      end else if (pattern_len_ff > LW'(MAX_PATTERN)) begin
         plen = LW'(MAX_PATTERN);
      end
      rlen = repl_len_ff;
      if (repl_len_ff > LW'(MAX_REPLACE)) begin
         rlen = LW'(MAX_REPLACE);
      end
   end

   // Control and output registers.
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RIDX_W-1:0]  ridx_ff, ridx_in;
   logic               le_ff, le_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]      rsp_byte_ff;
   logic               rsp_has_ff;
   logic               rsp_done_ff;

   // Cell row.
   sfr_pkg::cell_ctrl_type     cell_ctrl [MAX_PATTERN];
   logic [BW-1:0]              cell_byte [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]     cell_match;
   logic                       req_fire;
   logic                       do_shift;

   assign req_fire = req_valid && req_ready;

   for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
      logic [BW-1:0] next_byte;

      if (g == MAX_PATTERN - 1) begin : g_tail
         assign next_byte = '0;
      end else begin : g_body
         assign next_byte = cell_byte[g+1];
      end

      assign cell_ctrl[g].load  = req_fire && (cnt_ff == CNT_W'(g));
      assign cell_ctrl[g].shift = do_shift;

      sfr_cell u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl[g]),
         .load_byte    (req_data_byte),
         .next_byte    (next_byte),
         .pattern_byte (pattern_bytes_ff[BW*g +: BW]),
         .held_byte    (cell_byte[g]),
         .match        (cell_match[g])
      );
   end

   // The occupied cells all agree with the pattern, so the held bytes form a prefix.
   logic all_match;

   always_comb begin
      all_match = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (CNT_W'(i) < cnt_ff) begin
            all_match = all_match && cell_match[i];
         end
      end
   end

   logic [LW-1:0] cnt_ext;
   logic          slot_free;
   logic          full_hit;
   logic          stable;
   logic          repl_last;
   logic          emit;
   logic [BW-1:0] emit_byte;
   logic          emit_has;
   logic          emit_done;

   assign cnt_ext   = LW'(cnt_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full_hit  = (cnt_ext == plen) && all_match;
   // At a line end nothing stays held, so the remainder is never treated as settled.
   assign stable    = !le_ff && (cnt_ext < plen) && all_match;
   assign repl_last = ((LW'(ridx_ff) + LW'(1)) == rlen);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ridx_in   = ridx_ff;
      le_in     = le_ff;
      emit      = 1'b0;
      emit_byte = '0;
      emit_has  = 1'b1;
      emit_done = 1'b0;
      do_shift  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cnt_in   = cnt_ff + CNT_W'(1);
               le_in    = req_line_end;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (full_hit) begin
               cnt_in  = '0;
               ridx_in = '0;
               if (rlen != '0) begin
                  state_in = ST_REPL;
               end else if (le_ff) begin
                  state_in = ST_MARK;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (stable) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (cnt_ff == '0 || stable) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               emit      = 1'b1;
               emit_byte = cell_byte[0];
               emit_done = le_ff && (cnt_ff == CNT_W'(1));
               do_shift  = 1'b1;
               cnt_in    = cnt_ff - CNT_W'(1);
               if (le_ff && (cnt_ff == CNT_W'(1))) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPL: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_byte = repl_bytes_ff[BW*ridx_ff +: BW];
               emit_done = le_ff && repl_last;
               if (repl_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ridx_in = ridx_ff + RIDX_W'(1);
               end
            end
         end
         ST_MARK: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_has  = 1'b0;
               emit_done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ridx_ff <= ridx_in;
      le_ff   <= le_in;
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_has_ff  <= emit_has;
         rsp_done_ff <= emit_done;
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_has_byte  = rsp_has_ff;
   assign rsp_line_done = rsp_done_ff;

endmodule

/* rtl/sfr_checker.sv */
// Port-level checks for the streaming find-and-replace block, bound to its top level.
module sfr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sfr_pkg::BYTE_W-1:0]  rsp_out_byte,
   input logic                        rsp_has_byte,
   input logic                        rsp_line_done
);

   // Coming out of reset the block is empty and ready for an item.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // A waiting result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_has_byte)
          && $stable(rsp_line_done)))
      else $error("result changed while stalled");

   // An empty result only ever closes a line.
   a_marker_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_byte) |-> rsp_line_done)
      else $error("empty result without line end");

   // The end marker carries a zero byte.
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_byte) |-> (rsp_out_byte == '0))
      else $error("end marker with nonzero byte");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (.*);
